[hdl/i2cbm_pkg.sv]
// Shared constants for the I2C byte master: request codes, field widths, register map.
`timescale 1ns / 1ps
`default_nettype none
package i2cbm_pkg;

  localparam int ReqW   = 3;
  localparam int ByteW  = 8;
  localparam int CfgW   = 16;
  localparam int CfgIdxW = 1;
  localparam int BitCntW = 4;

  // Request codes carried by req_type.
  localparam logic [ReqW-1:0] REQ_NONE  = 3'd0;
  localparam logic [ReqW-1:0] REQ_START = 3'd1;
  localparam logic [ReqW-1:0] REQ_STOP  = 3'd2;
  localparam logic [ReqW-1:0] REQ_WRITE = 3'd3;
  localparam logic [ReqW-1:0] REQ_READ  = 3'd4;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_STEP_DELAY    = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_STRETCH_LIMIT = 1'd1;

  localparam logic [CfgW-1:0] STEP_DELAY_RST    = 16'd3000;
  localparam logic [CfgW-1:0] STRETCH_LIMIT_RST = 16'd30000;

  localparam logic [BitCntW-1:0] BITS_PER_BYTE = 4'd8;

endpackage
`default_nettype wire

[hdl/i2c_byte_master.sv]
// Top level of the I2C byte master: line sequencer, timing counters and result register.
//
// Usage: every input item is one tick of the bus clock domain. It carries an
// optional request (start, stop, write byte, read byte) and the sampled SCL and
// SDA levels. For every accepted item exactly one result item comes out: the
// open-drain drive-low levels for SCL and SDA, a busy flag, and a done pulse
// with the received ACK, the read byte and a clock-stretch timeout flag.
// Requests that arrive while a command is in progress are ignored.
// Throughput is one item per cycle while the receiver keeps up; the result of an item is registered and
// shows on the output channel the cycle after the item is accepted.
// The whole update for one tick is a single pass through the step sequencer
// and one add and compare on the delay or wait counter.
// When the receiver stalls, the finished result holds in the output register
// and input ready drops until it is taken; ready stays high while the output
// register is empty or being drained in the same cycle.
// Reset returns the sequencer to idle with both lines released, clears the
// counters and loads the default step delay and stretch limit.
// Configuration writes take effect at the next clock edge and are meant to be
// issued only while no command is in progress.
`timescale 1ns / 1ps
`default_nettype none
module i2c_byte_master #(
  parameter int COUNTER_WIDTH = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // Configuration write port
  input  wire logic                              cfg_we_i,
  input  wire logic [i2cbm_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  wire logic [i2cbm_pkg::CfgW-1:0]        cfg_data_i,
  // Input channel
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [i2cbm_pkg::ReqW-1:0]        req_type_i,
  input  wire logic [i2cbm_pkg::ByteW-1:0]       tx_byte_i,
  input  wire logic                              send_ack_i,
  input  wire logic                              scl_in_i,
  input  wire logic                              sda_in_i,
  // Output channel
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic                                   scl_drive_low_o,
  output logic                                   sda_drive_low_o,
  output logic                                   busy_res_o,
  output logic                                   done_res_o,
  output logic                                   ack_seen_o,
  output logic [i2cbm_pkg::ByteW-1:0]            rx_byte_o,
  output logic                                   stretch_timeout_o
);

  // The comparisons run at the wider of the counter and the register width.
  localparam int CmpW = (COUNTER_WIDTH > i2cbm_pkg::CfgW) ? COUNTER_WIDTH : i2cbm_pkg::CfgW;
  localparam logic [COUNTER_WIDTH-1:0] CntMax  = {COUNTER_WIDTH{1'b1}};
  localparam logic [COUNTER_WIDTH-1:0] CntZero = {COUNTER_WIDTH{1'b0}};

  // Sequencer states: one per delay or wait step of each command, plus idle.
  localparam logic [4:0] PH_IDLE  = 5'd0;
  localparam logic [4:0] S_ST_W   = 5'd1;   // start: wait SCL high
  localparam logic [4:0] S_ST_D1  = 5'd2;
  localparam logic [4:0] S_ST_D2  = 5'd3;
  localparam logic [4:0] S_ST_D3  = 5'd4;
  localparam logic [4:0] S_SP_D1  = 5'd5;   // stop
  localparam logic [4:0] S_SP_W   = 5'd6;
  localparam logic [4:0] S_SP_D2  = 5'd7;
  localparam logic [4:0] S_SP_D3  = 5'd8;
  localparam logic [4:0] S_WR_D1  = 5'd9;   // write: data bit
  localparam logic [4:0] S_WR_W   = 5'd10;
  localparam logic [4:0] S_WR_D2  = 5'd11;
  localparam logic [4:0] S_WR_D3  = 5'd12;
  localparam logic [4:0] S_WA_D1  = 5'd13;  // write: ACK slot
  localparam logic [4:0] S_WA_W   = 5'd14;
  localparam logic [4:0] S_WA_D2  = 5'd15;
  localparam logic [4:0] S_WA_D3  = 5'd16;
  localparam logic [4:0] S_RD_D1  = 5'd17;  // read: data bit
  localparam logic [4:0] S_RD_W   = 5'd18;
  localparam logic [4:0] S_RD_D2  = 5'd19;
  localparam logic [4:0] S_RD_D3  = 5'd20;
  localparam logic [4:0] S_RA_D1  = 5'd21;  // read: ACK/NACK slot
  localparam logic [4:0] S_RA_W   = 5'd22;
  localparam logic [4:0] S_RA_D2  = 5'd23;
  localparam logic [4:0] S_RA_D3  = 5'd24;

  logic [i2cbm_pkg::CfgW-1:0]    step_delay_q, stretch_limit_q;

  logic [4:0]                    phase_q, phase_d;
  logic [i2cbm_pkg::BitCntW-1:0] bit_count_q, bit_count_d;
  logic [i2cbm_pkg::ByteW-1:0]   shift_q, shift_d;
  logic [COUNTER_WIDTH-1:0]      delay_q, delay_d;
  logic [COUNTER_WIDTH-1:0]      wait_q, wait_d;
  logic                          drv_scl_q, drv_scl_d;
  logic                          drv_sda_q, drv_sda_d;
  logic                          ack_mode_q, ack_mode_d;
  logic                          timeout_q, timeout_d;

  logic                          out_valid_q;
  logic                          res_done_q, res_ack_q, res_timeout_q;
  logic [i2cbm_pkg::ByteW-1:0]   res_rx_q;

  logic                          in_fire;
  logic                          done_d, ack_d;
  logic [i2cbm_pkg::ByteW-1:0]   rx_d;
  logic [i2cbm_pkg::ByteW-1:0]   shift_next;
  logic [i2cbm_pkg::BitCntW-1:0] bit_inc;
  logic [COUNTER_WIDTH-1:0]      delay_inc;
  logic                          delay_end, wait_limit, is_wait, step_end;

  // A new item goes in whenever the result register is free or drains now.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  // Saturating delay counter and the end tests of both timed step kinds.
  assign delay_inc  = (delay_q == CntMax) ? delay_q : delay_q + 1'b1;
  assign delay_end  = (CmpW'(delay_inc) >= CmpW'(step_delay_q)) || (delay_inc == CntMax);
  assign wait_limit = (CmpW'(wait_q) >= CmpW'(stretch_limit_q)) || (wait_q == CntMax);
  assign is_wait    = (phase_q == S_ST_W) || (phase_q == S_SP_W) || (phase_q == S_WR_W) ||
                      (phase_q == S_WA_W) || (phase_q == S_RD_W) || (phase_q == S_RA_W);

  assign shift_next = {shift_q[i2cbm_pkg::ByteW-2:0], 1'b0};
  assign bit_inc    = bit_count_q + 1'b1;

  always_comb begin
    phase_d     = phase_q;
    bit_count_d = bit_count_q;
    shift_d     = shift_q;
    delay_d     = delay_q;
    wait_d      = wait_q;
    drv_scl_d   = drv_scl_q;
    drv_sda_d   = drv_sda_q;
    ack_mode_d  = ack_mode_q;
    timeout_d   = timeout_q;
    done_d      = 1'b0;
    ack_d       = 1'b0;
    rx_d        = '0;
    step_end    = 1'b0;

    if (phase_q == PH_IDLE) begin
      // Leading line changes of a new command happen on the accepting tick.
      case (req_type_i)
        i2cbm_pkg::REQ_START: begin
          drv_sda_d = 1'b0;
          drv_scl_d = 1'b0;
          phase_d   = S_ST_W;
        end
        i2cbm_pkg::REQ_STOP: begin
          drv_sda_d = 1'b1;
          phase_d   = S_SP_D1;
        end
        i2cbm_pkg::REQ_WRITE: begin
          drv_sda_d = !tx_byte_i[i2cbm_pkg::ByteW-1];
          phase_d   = S_WR_D1;
        end
        i2cbm_pkg::REQ_READ: begin
          drv_sda_d = 1'b0;
          phase_d   = S_RD_D1;
        end
        default: begin
        end
      endcase
      if (req_type_i == i2cbm_pkg::REQ_START || req_type_i == i2cbm_pkg::REQ_STOP ||
          req_type_i == i2cbm_pkg::REQ_WRITE || req_type_i == i2cbm_pkg::REQ_READ) begin
        bit_count_d = '0;
        delay_d     = CntZero;
        wait_d      = CntZero;
        timeout_d   = 1'b0;
        shift_d     = (req_type_i == i2cbm_pkg::REQ_WRITE) ? tx_byte_i : '0;
        ack_mode_d  = (req_type_i == i2cbm_pkg::REQ_READ) ? send_ack_i : 1'b0;
      end
    end else begin
      if (is_wait) begin
        if (scl_in_i) begin
          step_end = 1'b1;
        end else if (wait_limit) begin
          timeout_d = 1'b1;
          step_end  = 1'b1;
        end else begin
          wait_d = wait_q + 1'b1;
        end
      end else begin
        delay_d  = delay_inc;
        step_end = delay_end;
      end

      if (step_end) begin
        delay_d = CntZero;
        wait_d  = CntZero;
        unique case (phase_q)
          S_ST_W:  phase_d = S_ST_D1;
          S_ST_D1: begin drv_sda_d = 1'b1; phase_d = S_ST_D2; end
          S_ST_D2: begin drv_scl_d = 1'b1; phase_d = S_ST_D3; end
          S_ST_D3: begin done_d = 1'b1; phase_d = PH_IDLE; end
          S_SP_D1: begin drv_scl_d = 1'b0; phase_d = S_SP_W; end
          S_SP_W:  phase_d = S_SP_D2;
          S_SP_D2: begin drv_sda_d = 1'b0; phase_d = S_SP_D3; end
          S_SP_D3: begin done_d = 1'b1; phase_d = PH_IDLE; end
          S_WR_D1: begin drv_scl_d = 1'b0; phase_d = S_WR_W; end
          S_WR_W:  phase_d = S_WR_D2;
          S_WR_D2: begin drv_scl_d = 1'b1; phase_d = S_WR_D3; end
          S_WR_D3: begin
            // Next bit goes out MSB first; after the last one SDA is freed for ACK.
            shift_d     = shift_next;
            bit_count_d = bit_inc;
            if (bit_inc < i2cbm_pkg::BITS_PER_BYTE) begin
              drv_sda_d = !shift_next[i2cbm_pkg::ByteW-1];
              phase_d   = S_WR_D1;
            end else begin
              drv_sda_d = 1'b0;
              phase_d   = S_WA_D1;
            end
          end
          S_WA_D1: begin drv_scl_d = 1'b0; phase_d = S_WA_W; end
          S_WA_W:  phase_d = S_WA_D2;
          S_WA_D2: begin
            ack_mode_d = !sda_in_i;
            drv_scl_d  = 1'b1;
            phase_d    = S_WA_D3;
          end
          S_WA_D3: begin done_d = 1'b1; ack_d = ack_mode_q; phase_d = PH_IDLE; end
          S_RD_D1: begin drv_scl_d = 1'b0; phase_d = S_RD_W; end
          S_RD_W:  phase_d = S_RD_D2;
          S_RD_D2: begin
            shift_d   = {shift_q[i2cbm_pkg::ByteW-2:0], sda_in_i};
            drv_scl_d = 1'b1;
            phase_d   = S_RD_D3;
          end
          S_RD_D3: begin
            bit_count_d = bit_inc;
            if (bit_inc < i2cbm_pkg::BITS_PER_BYTE) begin
              phase_d = S_RD_D1;
            end else begin
              drv_sda_d = ack_mode_q;
              phase_d   = S_RA_D1;
            end
          end
          S_RA_D1: begin drv_scl_d = 1'b0; phase_d = S_RA_W; end
          S_RA_W:  phase_d = S_RA_D2;
          S_RA_D2: begin drv_scl_d = 1'b1; phase_d = S_RA_D3; end
          S_RA_D3: begin
            drv_sda_d = 1'b0;
            done_d    = 1'b1;
            rx_d      = shift_q;
            phase_d   = PH_IDLE;
          end
          default: phase_d = PH_IDLE;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_delay_q    <= i2cbm_pkg::STEP_DELAY_RST;
      stretch_limit_q <= i2cbm_pkg::STRETCH_LIMIT_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == i2cbm_pkg::CFG_STEP_DELAY) begin
        step_delay_q <= cfg_data_i;
      end
      if (cfg_idx_i == i2cbm_pkg::CFG_STRETCH_LIMIT) begin
        stretch_limit_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      bit_count_q <= '0;
      shift_q     <= '0;
      delay_q     <= CntZero;
      wait_q      <= CntZero;
      drv_scl_q   <= 1'b0;
      drv_sda_q   <= 1'b0;
      ack_mode_q  <= 1'b0;
      timeout_q   <= 1'b0;
    end else if (in_fire) begin
      phase_q     <= phase_d;
      bit_count_q <= bit_count_d;
      shift_q     <= shift_d;
      delay_q     <= delay_d;
      wait_q      <= wait_d;
      drv_scl_q   <= drv_scl_d;
      drv_sda_q   <= drv_sda_d;
      ack_mode_q  <= ack_mode_d;
      timeout_q   <= timeout_d;
    end
  end

  // Result register: the line drives are the state itself, so only the
  // per-tick flags need their own copy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_done_q    <= done_d;
      res_ack_q     <= ack_d;
      res_rx_q      <= rx_d;
      res_timeout_q <= done_d && timeout_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign scl_drive_low_o   = drv_scl_q;
  assign sda_drive_low_o   = drv_sda_q;
  assign busy_res_o        = (phase_q != PH_IDLE);
  assign done_res_o        = res_done_q;
  assign ack_seen_o        = res_ack_q;
  assign rx_byte_o         = res_rx_q;
  assign stretch_timeout_o = res_timeout_q;

endmodule
`default_nettype wire

[dv/i2cbm_line_checker.sv]
// Scoreboard for the I2C byte master: mirrors the line sequencer and checks every result item.
`timescale 1ns / 1ps
module i2cbm_line_checker #(
  parameter int COUNTER_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [i2cbm_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [i2cbm_pkg::CfgW-1:0]    cfg_data_i,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic [i2cbm_pkg::ReqW-1:0]    req_type_i,
  input  logic [i2cbm_pkg::ByteW-1:0]   tx_byte_i,
  input  logic                          send_ack_i,
  input  logic                          scl_in_i,
  input  logic                          sda_in_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic                          scl_drive_low_i,
  input  logic                          sda_drive_low_i,
  input  logic                          busy_res_i,
  input  logic                          done_res_i,
  input  logic                          ack_seen_i,
  input  logic [i2cbm_pkg::ByteW-1:0]   rx_byte_i,
  input  logic                          stretch_timeout_i,
  output int                            err_count_o,
  output int                            pending_o
);

  typedef struct packed {
    logic                        scl_low;
    logic                        sda_low;
    logic                        busy;
    logic                        done;
    logic                        ack;
    logic [i2cbm_pkg::ByteW-1:0] rx;
    logic                        tmo;
  } bus_result_t;

  // Sequencer steps. "HI" releases the line, "LO" pulls it low.
  typedef enum logic [3:0] {
    SQ_SDA_HI, SQ_SDA_LO, SQ_SCL_HI, SQ_SCL_LO, SQ_DATA_BIT, SQ_GET_ACK, SQ_GET_BIT,
    SQ_PUT_ACK, SQ_NEXT_WR, SQ_NEXT_RD, SQ_PAUSE, SQ_STRETCH, SQ_FINISH
  } seq_op_e;

  localparam int SEQ_LEN    = 52;
  localparam int PC_START   = 0;
  localparam int PC_STOP    = 9;
  localparam int PC_WRITE   = 17;
  localparam int PC_WR_LAST = 33;
  localparam int PC_READ    = 34;
  localparam int PC_RD_BIT  = 35;
  localparam int PC_RD_LAST = 51;
  localparam int PC_IDLE    = 63;
  localparam longint unsigned CNT_MAX = (64'd1 << COUNTER_WIDTH) - 64'd1;

  localparam seq_op_e SEQ [SEQ_LEN] = '{
    // start condition
    SQ_SDA_HI, SQ_SCL_HI, SQ_STRETCH, SQ_PAUSE, SQ_SDA_LO, SQ_PAUSE, SQ_SCL_LO, SQ_PAUSE,
    SQ_FINISH,
    // stop condition
    SQ_SDA_LO, SQ_PAUSE, SQ_SCL_HI, SQ_STRETCH, SQ_PAUSE, SQ_SDA_HI, SQ_PAUSE, SQ_FINISH,
    // write: eight data bits, then the acknowledge slot
    SQ_DATA_BIT, SQ_PAUSE, SQ_SCL_HI, SQ_STRETCH, SQ_PAUSE, SQ_SCL_LO, SQ_PAUSE, SQ_NEXT_WR,
    SQ_SDA_HI, SQ_PAUSE, SQ_SCL_HI, SQ_STRETCH, SQ_PAUSE, SQ_GET_ACK, SQ_SCL_LO, SQ_PAUSE,
    SQ_FINISH,
    // read: eight sampled bits, then our ACK or NACK
    SQ_SDA_HI, SQ_PAUSE, SQ_SCL_HI, SQ_STRETCH, SQ_PAUSE, SQ_GET_BIT, SQ_SCL_LO, SQ_PAUSE,
    SQ_NEXT_RD,
    SQ_PUT_ACK, SQ_PAUSE, SQ_SCL_HI, SQ_STRETCH, SQ_PAUSE, SQ_SCL_LO, SQ_PAUSE, SQ_SDA_HI,
    SQ_FINISH
  };

  int                            pc;
  logic [i2cbm_pkg::BitCntW-1:0] nbits;
  logic [i2cbm_pkg::ByteW-1:0]   shreg;
  longint unsigned               dly_cnt;
  longint unsigned               wt_cnt;
  logic                          drv_scl;
  logic                          drv_sda;
  logic                          ack_flag;
  logic                          tmo_flag;
  logic [i2cbm_pkg::CfgW-1:0]    cur_delay;
  logic [i2cbm_pkg::CfgW-1:0]    cur_limit;
  logic                          fin;
  logic                          fin_ack;
  logic [i2cbm_pkg::ByteW-1:0]   fin_rx;

  bus_result_t exp_q[$];
  bus_result_t want;
  bus_result_t got;
  int          n_err;
  int          n_res;

  // Runs the zero-time steps until a pause, a stretch wait or the end of the command.
  function automatic void walk_steps(input logic sda);
    int guard;
    for (guard = 0; guard < 2 * SEQ_LEN; guard++) begin
      if (pc >= SEQ_LEN) begin
        pc = PC_IDLE;
        return;
      end
      case (SEQ[pc])
        SQ_SDA_HI:   begin drv_sda = 1'b0; pc++; end
        SQ_SDA_LO:   begin drv_sda = 1'b1; pc++; end
        SQ_SCL_HI:   begin drv_scl = 1'b0; pc++; end
        SQ_SCL_LO:   begin drv_scl = 1'b1; pc++; end
        SQ_DATA_BIT: begin drv_sda = ~shreg[i2cbm_pkg::ByteW-1]; pc++; end
        SQ_GET_ACK:  begin ack_flag = ~sda; pc++; end
        SQ_GET_BIT:  begin shreg = {shreg[i2cbm_pkg::ByteW-2:0], sda}; pc++; end
        SQ_PUT_ACK:  begin drv_sda = ack_flag; pc++; end
        SQ_NEXT_WR: begin
          shreg = shreg << 1;
          nbits = nbits + 1'b1;
          pc = (nbits < i2cbm_pkg::BITS_PER_BYTE) ? PC_WRITE : pc + 1;
        end
        SQ_NEXT_RD: begin
          nbits = nbits + 1'b1;
          pc = (nbits < i2cbm_pkg::BITS_PER_BYTE) ? PC_RD_BIT : pc + 1;
        end
        SQ_FINISH: begin
          fin = 1'b1;
          if (pc == PC_WR_LAST) fin_ack = ack_flag;
          if (pc == PC_RD_LAST) fin_rx = shreg;
          pc = PC_IDLE;
          return;
        end
        default: return;
      endcase
    end
    pc = PC_IDLE;
  endfunction

  function automatic bus_result_t predict_tick(input logic [i2cbm_pkg::ReqW-1:0] req,
                                               input logic [i2cbm_pkg::ByteW-1:0] tx,
                                               input logic ack,
                                               input logic scl, input logic sda);
    bus_result_t r;
    logic ended;
    fin = 1'b0;
    fin_ack = 1'b0;
    fin_rx = '0;
    if (pc >= SEQ_LEN) begin
      pc = PC_IDLE;
      if (req == i2cbm_pkg::REQ_START || req == i2cbm_pkg::REQ_STOP ||
          req == i2cbm_pkg::REQ_WRITE || req == i2cbm_pkg::REQ_READ) begin
        case (req)
          i2cbm_pkg::REQ_START: pc = PC_START;
          i2cbm_pkg::REQ_STOP:  pc = PC_STOP;
          i2cbm_pkg::REQ_WRITE: pc = PC_WRITE;
          default:              pc = PC_READ;
        endcase
        nbits = '0;
        dly_cnt = 0;
        wt_cnt = 0;
        tmo_flag = 1'b0;
        shreg = (req == i2cbm_pkg::REQ_WRITE) ? tx : '0;
        ack_flag = (req == i2cbm_pkg::REQ_READ) ? ack : 1'b0;
        walk_steps(sda);
      end
    end else begin
      ended = 1'b0;
      if (SEQ[pc] == SQ_PAUSE) begin
        if (dly_cnt < CNT_MAX) dly_cnt++;
        if (dly_cnt >= cur_delay || dly_cnt >= CNT_MAX) ended = 1'b1;
      end else if (SEQ[pc] == SQ_STRETCH) begin
        if (scl) begin
          ended = 1'b1;
        end else if (wt_cnt >= cur_limit || wt_cnt >= CNT_MAX) begin
          tmo_flag = 1'b1;
          ended = 1'b1;
        end else begin
          wt_cnt++;
        end
      end else begin
        ended = 1'b1;
      end
      if (ended) begin
        pc++;
        dly_cnt = 0;
        wt_cnt = 0;
        walk_steps(sda);
      end
    end
    r.scl_low = drv_scl;
    r.sda_low = drv_sda;
    r.busy = (pc < SEQ_LEN);
    r.done = fin;
    r.ack = fin_ack;
    r.rx = fin_rx;
    r.tmo = fin & tmo_flag;
    return r;
  endfunction

  task automatic log_mismatch(input string why, input bus_result_t w, input bus_result_t g);
    n_err++;
    if (n_err <= 10) begin
      $display("[%0t] %s at result %0d: expected scl=%b sda=%b busy=%b done=%b ack=%b rx=%02h",
               $time, why, n_res, w.scl_low, w.sda_low, w.busy, w.done, w.ack, w.rx);
      $display("    tmo=%b | got scl=%b sda=%b busy=%b done=%b ack=%b rx=%02h tmo=%b",
               w.tmo, g.scl_low, g.sda_low, g.busy, g.done, g.ack, g.rx, g.tmo);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc = PC_IDLE;
      nbits = '0;
      shreg = '0;
      dly_cnt = 0;
      wt_cnt = 0;
      drv_scl = 1'b0;
      drv_sda = 1'b0;
      ack_flag = 1'b0;
      tmo_flag = 1'b0;
      cur_delay = i2cbm_pkg::STEP_DELAY_RST;
      cur_limit = i2cbm_pkg::STRETCH_LIMIT_RST;
      exp_q.delete();
      n_err = 0;
      n_res = 0;
      err_count_o <= 0;
      pending_o <= 0;
    end else begin
      // Results are compared before this edge's item is predicted, so a result can
      // never be matched against the item that is accepted together with it.
      if (out_valid_i && out_ready_i) begin
        got = {scl_drive_low_i, sda_drive_low_i, busy_res_i, done_res_i, ack_seen_i,
               rx_byte_i, stretch_timeout_i};
        n_res++;
        if (exp_q.size() == 0) begin
          log_mismatch("result with no item waiting", '0, got);
        end else begin
          want = exp_q.pop_front();
          if (got !== want) log_mismatch("mismatch", want, got);
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == i2cbm_pkg::CFG_STEP_DELAY) cur_delay = cfg_data_i;
        else if (cfg_idx_i == i2cbm_pkg::CFG_STRETCH_LIMIT) cur_limit = cfg_data_i;
      end
      if (in_valid_i && in_ready_i) begin
        exp_q.push_back(predict_tick(req_type_i, tx_byte_i, send_ack_i, scl_in_i, sda_in_i));
      end
      err_count_o <= n_err;
      pending_o <= exp_q.size();
    end
  end

endmodule

[dv/tb_i2c_byte_master.sv]
// Testbench top for the I2C byte master: clock, reset, stimulus, configuration and verdict.
`timescale 1ns / 1ps
module tb_i2c_byte_master;

  localparam int CounterW = 16;
  // Generous cycle budget. Most of a correct run is spent in the random phases
  // with heavy sender gaps or receiver stalls.
  localparam longint unsigned CycleLimit = 200_000;

  // How the SDA input behaves on the ticks of a directed command.
  localparam int SdaAllLow  = 0;
  localparam int SdaAllHigh = 1;
  localparam int SdaRandom  = 2;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [i2cbm_pkg::CfgIdxW-1:0] cfg_idx_i;
  logic [i2cbm_pkg::CfgW-1:0]    cfg_data_i;
  logic                          in_valid_i;
  logic                          in_ready_o;
  logic [i2cbm_pkg::ReqW-1:0]    req_type_i;
  logic [i2cbm_pkg::ByteW-1:0]   tx_byte_i;
  logic                          send_ack_i;
  logic                          scl_in_i;
  logic                          sda_in_i;
  logic                          out_valid_o;
  logic                          out_ready_i;
  logic                          scl_drive_low_o;
  logic                          sda_drive_low_o;
  logic                          busy_res_o;
  logic                          done_res_o;
  logic                          ack_seen_o;
  logic [i2cbm_pkg::ByteW-1:0]   rx_byte_o;
  logic                          stretch_timeout_o;

  int              err_count;
  int              pending;
  int              src_idle = 0;
  int              sink_idle = 0;
  logic            last_busy;
  longint unsigned cycles = 0;

  i2c_byte_master #(
    .COUNTER_WIDTH(CounterW)
  ) DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .req_type_i       (req_type_i),
    .tx_byte_i        (tx_byte_i),
    .send_ack_i       (send_ack_i),
    .scl_in_i         (scl_in_i),
    .sda_in_i         (sda_in_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .scl_drive_low_o  (scl_drive_low_o),
    .sda_drive_low_o  (sda_drive_low_o),
    .busy_res_o       (busy_res_o),
    .done_res_o       (done_res_o),
    .ack_seen_o       (ack_seen_o),
    .rx_byte_o        (rx_byte_o),
    .stretch_timeout_o(stretch_timeout_o)
  );

  i2cbm_line_checker #(
    .COUNTER_WIDTH(CounterW)
  ) u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .req_type_i       (req_type_i),
    .tx_byte_i        (tx_byte_i),
    .send_ack_i       (send_ack_i),
    .scl_in_i         (scl_in_i),
    .sda_in_i         (sda_in_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .scl_drive_low_i  (scl_drive_low_o),
    .sda_drive_low_i  (sda_drive_low_o),
    .busy_res_i       (busy_res_o),
    .done_res_i       (done_res_o),
    .ack_seen_i       (ack_seen_o),
    .rx_byte_i        (rx_byte_o),
    .stretch_timeout_i(stretch_timeout_o),
    .err_count_o      (err_count),
    .pending_o        (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // The receiver stalls at random with the current idle percentage. A fresh
  // choice every edge keeps the stalls falling on every phase of a command.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= sink_idle);
  end

  // Busy flag of the most recently taken result item. Once no item is in
  // flight it tells whether a command is still running inside the block.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_busy <= 1'b0;
    end else if (out_valid_o && out_ready_i) begin
      last_busy <= busy_res_o;
    end
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic [i2cbm_pkg::ByteW-1:0] any_byte();
    logic [31:0] r;
    r = $urandom();
    return r[i2cbm_pkg::ByteW-1:0];
  endfunction

  function automatic logic any_bit();
    logic [31:0] r;
    r = $urandom();
    return r[0];
  endfunction

  function automatic logic [i2cbm_pkg::CfgW-1:0] cfg_value(input int lo, input int hi);
    logic [31:0] r;
    r = $urandom_range(hi, lo);
    return r[i2cbm_pkg::CfgW-1:0];
  endfunction

  // Any request code, now and then one of the unused ones.
  function automatic logic [i2cbm_pkg::ReqW-1:0] any_request();
    logic [31:0] r;
    if ($urandom_range(0, 7) == 0) begin
      r = $urandom_range(32'(i2cbm_pkg::REQ_READ) + 32'd1,
                         (32'd1 << i2cbm_pkg::ReqW) - 32'd1);
    end else begin
      r = $urandom_range(32'(i2cbm_pkg::REQ_START), 32'(i2cbm_pkg::REQ_READ));
    end
    return r[i2cbm_pkg::ReqW-1:0];
  endfunction

  function automatic logic sda_level(input int mode);
    if (mode == SdaAllLow) return 1'b0;
    if (mode == SdaAllHigh) return 1'b1;
    return any_bit();
  endfunction

  // Offers one item (one bus tick) and returns at the edge that accepts it.
  // Must be called right after a rising edge. Valid is only lowered when a
  // sender gap is taken, so back-to-back items keep valid high throughout.
  task automatic send_tick(input logic [i2cbm_pkg::ReqW-1:0] req,
                           input logic [i2cbm_pkg::ByteW-1:0] tx,
                           input logic ack, input logic scl, input logic sda);
    if ($urandom_range(0, 99) < src_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(0, 99) < src_idle) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= req;
    tx_byte_i <= tx;
    send_ack_i <= ack;
    scl_in_i <= scl;
    sda_in_i <= sda;
    // Ready is sampled at the falling edge, where it is settled.
    @(negedge clk_i);
    while (!in_ready_o) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // Stops offering items until every expected result item has been taken.
  task automatic wait_results();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // Feeds empty ticks until the running command has finished, then pauses so
  // that a register write cannot land on a live command.
  task automatic drain_busy();
    wait_results();
    while (last_busy) begin
      send_tick(i2cbm_pkg::REQ_NONE, any_byte(), any_bit(), 1'b1, any_bit());
      wait_results();
    end
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [i2cbm_pkg::CfgIdxW-1:0] idx,
                           input logic [i2cbm_pkg::CfgW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // One directed command, run to its end. The first scl_low ticks after the
  // request hold SCL low (clock stretching); with noisy set, the follow-up ticks
  // carry random requests that the block must ignore while it is busy.
  task automatic run_cmd(input logic [i2cbm_pkg::ReqW-1:0] req,
                         input logic [i2cbm_pkg::ByteW-1:0] tx,
                         input logic ack, input int scl_low, input int sda_mode,
                         input logic noisy);
    int k;
    k = 0;
    send_tick(req, tx, ack, 1'b1, sda_level(sda_mode));
    wait_results();
    while (last_busy) begin
      send_tick(noisy ? any_request() : i2cbm_pkg::REQ_NONE, any_byte(), any_bit(),
                (k >= scl_low), sda_level(sda_mode));
      k++;
      wait_results();
    end
    repeat (2) @(posedge clk_i);
  endtask

  initial begin
    int ph;
    int n_items;
    logic [i2cbm_pkg::ReqW-1:0] req;

    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= i2cbm_pkg::CFG_STEP_DELAY;
    cfg_data_i <= '0;
    in_valid_i <= 1'b0;
    req_type_i <= i2cbm_pkg::REQ_NONE;
    tx_byte_i <= '0;
    send_ack_i <= 1'b0;
    scl_in_i <= 1'b1;
    sda_in_i <= 1'b1;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: a short step delay and a small stretch limit.
    write_reg(i2cbm_pkg::CFG_STEP_DELAY, 16'd1);
    write_reg(i2cbm_pkg::CFG_STRETCH_LIMIT, 16'd2);

    // Unused request codes and an empty tick while idle: nothing may start.
    send_tick(i2cbm_pkg::REQ_READ + 3'd1, 8'h00, 1'b0, 1'b1, 1'b1);
    send_tick(i2cbm_pkg::REQ_READ + 3'd2, 8'hFF, 1'b1, 1'b0, 1'b0);
    send_tick({i2cbm_pkg::ReqW{1'b1}}, 8'h81, 1'b1, 1'b1, 1'b0);
    send_tick(i2cbm_pkg::REQ_NONE, 8'h7E, 1'b0, 1'b0, 1'b1);
    drain_busy();

    // Start with a stretch that ends within the limit.
    run_cmd(i2cbm_pkg::REQ_START, 8'h00, 1'b0, 2, SdaRandom, 1'b0);
    // Write all ones with no acknowledge, then all zeros acknowledged while
    // requests keep arriving (also on the finishing tick) and are ignored.
    run_cmd(i2cbm_pkg::REQ_WRITE, 8'hFF, 1'b0, 0, SdaAllHigh, 1'b0);
    run_cmd(i2cbm_pkg::REQ_WRITE, 8'h00, 1'b1, 0, SdaAllLow, 1'b1);
    // Reads: all ones with ACK, all zeros with NACK, random data.
    run_cmd(i2cbm_pkg::REQ_READ, 8'h00, 1'b1, 0, SdaAllHigh, 1'b0);
    run_cmd(i2cbm_pkg::REQ_READ, 8'hFF, 1'b0, 0, SdaAllLow, 1'b0);
    run_cmd(i2cbm_pkg::REQ_READ, 8'hA5, 1'b1, 0, SdaRandom, 1'b1);
    // Stop whose stretch ends within the limit.
    run_cmd(i2cbm_pkg::REQ_STOP, 8'h5A, 1'b0, 3, SdaRandom, 1'b0);

    // A zero stretch limit times out on the first low tick.
    write_reg(i2cbm_pkg::CFG_STRETCH_LIMIT, 16'd0);
    run_cmd(i2cbm_pkg::REQ_START, 8'h00, 1'b1, 1, SdaRandom, 1'b0);
    // A zero step delay behaves as a step delay of one.
    write_reg(i2cbm_pkg::CFG_STEP_DELAY, 16'd0);
    run_cmd(i2cbm_pkg::REQ_WRITE, 8'h96, 1'b0, 0, SdaRandom, 1'b0);
    run_cmd(i2cbm_pkg::REQ_STOP, 8'h00, 1'b0, 0, SdaRandom, 1'b0);

    // Random part in three idling regimes. Requests come often enough that
    // commands run back to back; most are ignored because the block is busy,
    // which is what keeps the sequencer deep in its programs. SCL is held low
    // on a few ticks so stretch waits both pass and time out.
    for (ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          src_idle = 29;
          sink_idle = 79;
          write_reg(i2cbm_pkg::CFG_STEP_DELAY, cfg_value(0, 3));
          write_reg(i2cbm_pkg::CFG_STRETCH_LIMIT, cfg_value(0, 4));
          n_items = 220;
        end
        1: begin
          src_idle = 79;
          sink_idle = 29;
          write_reg(i2cbm_pkg::CFG_STEP_DELAY, cfg_value(1, 6));
          write_reg(i2cbm_pkg::CFG_STRETCH_LIMIT, 16'hFFFF);
          n_items = 220;
        end
        default: begin
          src_idle = 0;
          sink_idle = 0;
          write_reg(i2cbm_pkg::CFG_STEP_DELAY, 16'd1);
          write_reg(i2cbm_pkg::CFG_STRETCH_LIMIT, 16'd1);
          n_items = 200;
        end
      endcase
      repeat (n_items) begin
        req = i2cbm_pkg::REQ_NONE;
        if ($urandom_range(0, 99) < 35) req = any_request();
        send_tick(req, any_byte(), any_bit(), ($urandom_range(0, 99) >= 8), any_bit());
      end
      drain_busy();
    end

    wait_results();
    repeat (4) @(posedge clk_i);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[files.f]
hdl/i2cbm_pkg.sv
hdl/i2c_byte_master.sv
dv/i2cbm_line_checker.sv
dv/tb_i2c_byte_master.sv
